// ----- design/cbm_pkg.sv -----
`default_nettype none

package cbm_pkg;

    // Input item kinds
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_PRG_RD = 2'd2;
    localparam logic [1:0] KIND_CHR_RD = 2'd3;

    // Register pages (address bits 15..12)
    localparam logic [3:0] PAGE_PRG01  = 4'h8;
    localparam logic [3:0] PAGE_PRG2   = 4'h9;
    localparam logic [3:0] PAGE_CHR01  = 4'hA;
    localparam logic [3:0] PAGE_CHR23  = 4'hB;
    localparam logic [3:0] PAGE_CHR45  = 4'hC;
    localparam logic [3:0] PAGE_CHR67  = 4'hD;
    localparam logic [3:0] PAGE_RELOAD = 4'hE;
    localparam logic [3:0] PAGE_CTRL   = 4'hF;

    // Sub-addresses on the control page
    localparam logic [1:0] SUB_LOAD   = 2'd0;
    localparam logic [1:0] SUB_ENABLE = 2'd1;
    localparam logic [1:0] SUB_MIRROR = 2'd2;

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    localparam int COUNT_W = 18;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_PRG_WR,
        OP_CHR_WR,
        OP_RELOAD_WR,
        OP_LOAD,
        OP_ENABLE,
        OP_MIRROR,
        OP_TICK,
        OP_PRG_RD,
        OP_CHR_RD
    } t_opcode;

    typedef struct packed {
        t_opcode     op;
        logic [2:0]  slot;
        logic        hi;
        logic [7:0]  data;
        logic [15:0] addr;
    } t_op;

endpackage

`default_nettype wire

// ----- design/cbm_front.sv -----
`default_nettype none

module cbm_front
    import cbm_pkg::*;
(
    input  wire logic        i_valid,
    input  wire logic        i_full,
    input  wire logic [1:0]  i_kind,
    input  wire logic [15:0] i_bus_address,
    input  wire logic [7:0]  i_bus_data,
    output logic             o_stall,
    output logic             o_push,
    output t_op              o_op
);

    logic [3:0] page;
    logic [1:0] sub;
    logic [3:0] chr_rel;

    assign page    = i_bus_address[15:12];
    assign sub     = i_bus_address[1:0];
    assign chr_rel = page - PAGE_CHR01;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    // Decode the register map once here so the back end only sees operations.
    always_comb begin
        o_op.op   = OP_NOP;
        o_op.slot = 3'd0;
        o_op.hi   = sub[0];
        o_op.data = i_bus_data;
        o_op.addr = i_bus_address;
        unique case (i_kind)
            KIND_TICK:   o_op.op = OP_TICK;
            KIND_PRG_RD: o_op.op = OP_PRG_RD;
            KIND_CHR_RD: o_op.op = OP_CHR_RD;
            KIND_WRITE: begin
                unique case (page)
                    PAGE_PRG01: begin
                        o_op.op   = OP_PRG_WR;
                        o_op.slot = {2'b00, sub[1]};
                    end
                    PAGE_PRG2: begin
                        if (!sub[1]) begin
                            o_op.op   = OP_PRG_WR;
                            o_op.slot = 3'd2;
                        end
                    end
                    PAGE_CHR01, PAGE_CHR23, PAGE_CHR45, PAGE_CHR67: begin
                        o_op.op   = OP_CHR_WR;
                        o_op.slot = {chr_rel[1:0], sub[1]};
                    end
                    PAGE_RELOAD: begin
                        o_op.op   = OP_RELOAD_WR;
                        o_op.slot = {1'b0, sub};
                    end
                    PAGE_CTRL: begin
                        unique case (sub)
                            SUB_LOAD:   o_op.op = OP_LOAD;
                            SUB_ENABLE: o_op.op = OP_ENABLE;
                            SUB_MIRROR: o_op.op = OP_MIRROR;
                            default:    o_op.op = OP_NOP;
                        endcase
                    end
                    default: o_op.op = OP_NOP;
                endcase
            end
            default: o_op.op = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ----- design/cbm_queue.sv -----
`default_nettype none

module cbm_queue
    import cbm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_op,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_op       o_op
);

    t_op                 r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCOUNT_W-1:0] r_count;
    logic [QCOUNT_W-1:0] n_count;

    assign o_full  = (r_count == QCOUNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCOUNT_W'(QDEPTH))
        else $error("queue occupancy beyond depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> !o_full)
        else $error("push into full queue");

endmodule

`default_nettype wire

// ----- design/cbm_back.sv -----
`default_nettype none

module cbm_back
    import cbm_pkg::*;
#(
    parameter int CYCLES_PER_LINE = 113
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_empty,
    input  wire t_op    i_op,
    input  wire logic   i_stall,
    output logic        o_pop,
    output logic        o_valid,
    output logic [20:0] o_rom_offset,
    output logic [1:0]  o_mirroring,
    output logic        o_irq_pulse
);

    localparam logic [COUNT_W-1:0] LINE_STEP = COUNT_W'(CYCLES_PER_LINE);
    localparam logic [7:0] FIXED_BANK = 8'hFF;

    logic [7:0]         r_prg [3];
    logic [7:0]         r_chr [8];
    logic [1:0]         r_mirror;
    logic               r_irq_en;
    logic [15:0]        r_reload;
    logic [15:0]        r_mask;
    logic [COUNT_W-1:0] r_count;

    logic [7:0]         n_prg [3];
    logic [7:0]         n_chr [8];
    logic [1:0]         n_mirror;
    logic               n_irq_en;
    logic [15:0]        n_reload;
    logic [15:0]        n_mask;
    logic [COUNT_W-1:0] n_count;
    logic [20:0]        n_offset;
    logic               n_irq;

    logic               r_out_valid;
    logic [20:0]        r_out_offset;
    logic               r_out_irq;

    logic [1:0]         window;
    logic [7:0]         prg_bank;
    logic               fired;

    function automatic logic [7:0] set_nibble(input logic [7:0] old, input logic hi,
                                              input logic [7:0] data);
        set_nibble = hi ? {data[3:0], old[3:0]} : {old[7:4], data[3:0]};
    endfunction

    assign o_pop        = !i_empty && (!r_out_valid || !i_stall);
    assign o_valid      = r_out_valid;
    assign o_rom_offset = r_out_offset;
    assign o_mirroring  = r_mirror;
    assign o_irq_pulse  = r_out_irq;

    assign window   = i_op.addr[14:13];
    assign prg_bank = (window == 2'd3) ? FIXED_BANK : r_prg[window];
    assign fired    = r_count[COUNT_W-1] || (r_count == '0);

    always_comb begin
        n_prg    = r_prg;
        n_chr    = r_chr;
        n_mirror = r_mirror;
        n_irq_en = r_irq_en;
        n_reload = r_reload;
        n_mask   = r_mask;
        n_count  = r_count;
        n_offset = '0;
        n_irq    = 1'b0;
        unique case (i_op.op)
            OP_PRG_WR: begin
                n_prg[i_op.slot[1:0]] = set_nibble(r_prg[i_op.slot[1:0]], i_op.hi, i_op.data);
            end
            OP_CHR_WR: begin
                n_chr[i_op.slot] = set_nibble(r_chr[i_op.slot], i_op.hi, i_op.data);
            end
            OP_RELOAD_WR: begin
                n_reload[{i_op.slot[1:0], 2'b00} +: 4] = i_op.data[3:0];
            end
            OP_LOAD: begin
                n_count = {2'b00, r_reload & r_mask};
            end
            OP_ENABLE: begin
                n_irq_en = i_op.data[0];
                priority if (i_op.data[3]) n_mask = 16'h000F;
                else if (i_op.data[2])     n_mask = 16'h00FF;
                else if (i_op.data[1])     n_mask = 16'h0FFF;
                else                       n_mask = 16'hFFFF;
            end
            OP_MIRROR: begin
                n_mirror = i_op.data[1:0];
            end
            OP_TICK: begin
                if (r_irq_en) begin
                    n_irq   = fired;
                    n_count = (fired ? '0 : r_count) - LINE_STEP;
                end
            end
            OP_PRG_RD: begin
                if (i_op.addr[15]) begin
                    n_offset = {prg_bank, i_op.addr[12:0]};
                end
            end
            OP_CHR_RD: begin
                n_offset = {3'b000, r_chr[i_op.addr[12:10]], i_op.addr[9:0]};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg       <= '{default: '0};
            r_chr       <= '{default: '0};
            r_mirror    <= '0;
            r_irq_en    <= 1'b0;
            r_reload    <= '0;
            r_mask      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_prg    <= n_prg;
                r_chr    <= n_chr;
                r_mirror <= n_mirror;
                r_irq_en <= n_irq_en;
                r_reload <= n_reload;
                r_mask   <= n_mask;
                r_count  <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_offset <= n_offset;
            r_out_irq    <= n_irq;
        end
    end

    a_irq_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_irq) |-> r_irq_en)
        else $error("interrupt reported while disabled");

    a_irq_no_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_irq) |-> (r_out_offset == '0))
        else $error("interrupt result carries an offset");

    a_hold_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !r_irq_en && i_op.op == OP_TICK) |=> $stable(r_count))
        else $error("counter moved while disabled");

endmodule

`default_nettype wire

// ----- design/cartridge_bank_mapper_scanline_irq.sv -----
// An accepted transaction is queued, then executed by the back end into its output register.
// Throughput: one transaction per cycle while the output is not stalled.
// A four-entry command queue lets the input keep accepting while the output is stalled.
// Reset (synchronous, active low) clears all bank, counter and mode registers to zero,
// empties the queue and drops the output valid.
`default_nettype none

module cartridge_bank_mapper_scanline_irq
    import cbm_pkg::*;
#(
    parameter int CYCLES_PER_LINE = 113
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [15:0] i_bus_address,
    input  wire logic [7:0]  i_bus_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [20:0]      o_rom_offset,
    output logic [1:0]       o_mirroring,
    output logic             o_irq_pulse
);

    // The front end turns each incoming transaction into a decoded operation.
    // Register writes are classified by page and sub-address so that the back
    // end never has to look at the raw register map.
    logic push;
    logic pop;
    logic full;
    logic empty;
    t_op  front_op;
    t_op  head_op;

    cbm_front u_front (
        .i_valid       (i_valid),
        .i_full        (full),
        .i_kind        (i_kind),
        .i_bus_address (i_bus_address),
        .i_bus_data    (i_bus_data),
        .o_stall       (o_stall),
        .o_push        (push),
        .o_op          (front_op)
    );

    // The queue decouples the two halves: the input side stalls only once it
    // is full, and the output side may hold a result without blocking entry.
    cbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_op    (head_op)
    );

    // The back end holds all mapper state and executes operations strictly in
    // order, one per cycle, whenever its output register is free or being
    // emptied in the same cycle.
    cbm_back #(
        .CYCLES_PER_LINE (CYCLES_PER_LINE)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_op         (head_op),
        .i_stall      (i_stall),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_rom_offset (o_rom_offset),
        .o_mirroring  (o_mirroring),
        .o_irq_pulse  (o_irq_pulse)
    );

endmodule

`default_nettype wire
